>>> rtl/swsv_pkg.sv
// ----------------------------------------------------------------------------
// swsv_pkg: shared types and helpers for the sphere wall slide block
// Payload structs of both channels, pipeline sideband types and the
// leading-one search used by the block scaling stages.
// ----------------------------------------------------------------------------
package swsv_pkg;

  typedef struct packed {
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] slide_x;
    logic signed [15:0] slide_y;
    logic signed [15:0] slide_z;
    logic               degenerate;
  } out_t;

  // Sideband that rides along the square root pipeline.
  typedef struct packed {
    logic [2:0][30:0] mag;
    logic [2:0]       neg;
    logic             degen;
  } sqrt_side_t;

  // Sideband that rides along the divider pipeline.
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } div_side_t;

  localparam logic [31:0] SAT_POS = 32'd32767;
  localparam logic [31:0] SAT_NEG = 32'd32768;

  // Position of the highest set bit; zero for a zero word.
  function automatic logic [5:0] msb_pos(logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

>>> rtl/swsv_isqrt.sv
// ----------------------------------------------------------------------------
// swsv_isqrt: pipelined 64-bit integer square root
// One digit-by-digit step per register stage, 32 stages, floor result.
// ----------------------------------------------------------------------------
module swsv_isqrt #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  logic [63:0]       x_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid_out,
  output logic [31:0]       root_out,
  output logic [SIDE_W-1:0] side_out
);

  localparam int STEPS = 32;

  logic [63:0]       x_r    [STEPS];
  logic [63:0]       root_r [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];
  logic              vld_r  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [63:0]       x_p, root_p, bit_c, x_nxt, root_nxt;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [64:0]       trial;

    if (k == 0) begin : g_first
      assign x_p    = x_in;
      assign root_p = '0;
      assign side_p = side_in;
      assign vld_p  = valid_in;
    end else begin : g_next
      assign x_p    = x_r[k-1];
      assign root_p = root_r[k-1];
      assign side_p = side_r[k-1];
      assign vld_p  = vld_r[k-1];
    end

    assign bit_c = 64'(1) << (62 - 2 * k);
    assign trial = {1'b0, root_p} + {1'b0, bit_c};

    always_comb begin
      if ({1'b0, x_p} >= trial) begin
        x_nxt    = x_p - trial[63:0];
        root_nxt = (root_p >> 1) + bit_c;
      end else begin
        x_nxt    = x_p;
        root_nxt = root_p >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_p;
      end
    end
  end

  assign valid_out = vld_r[STEPS-1];
  assign root_out  = root_r[STEPS-1][31:0];
  assign side_out  = side_r[STEPS-1];

endmodule

>>> rtl/swsv_div.sv
// ----------------------------------------------------------------------------
// swsv_div: three-lane pipelined rounding divider
// Computes round(mag * 2^FRAC_BITS / len) per lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module swsv_div #(
  parameter int FRAC_BITS = 14,
  parameter int SIDE_W    = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_in,
  input  logic [2:0][30:0]          mag_in,
  input  logic [31:0]               len_in,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      valid_out,
  output logic [2:0][FRAC_BITS:0]   quot_out,
  output logic [SIDE_W-1:0]         side_out
);

  // The magnitude never exceeds the length, so the quotient fits in FRAC_BITS+1 bits.
  localparam int QW = FRAC_BITS + 1;
  localparam int RW = FRAC_BITS + 32;

  logic [RW-1:0]     rem_r  [QW][3];
  logic [QW-1:0]     quot_r [QW][3];
  logic [31:0]       len_r  [QW];
  logic [SIDE_W-1:0] side_r [QW];
  logic              vld_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0]     rem_p [3];
    logic [QW-1:0]     quot_p [3];
    logic [RW-1:0]     rem_nxt [3];
    logic [QW-1:0]     quot_nxt [3];
    logic [31:0]       len_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [RW-1:0]     sub_c;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_p[l]  = (RW'(mag_in[l]) << FRAC_BITS) + RW'(len_in >> 1);
        assign quot_p[l] = '0;
      end
      assign len_p  = len_in;
      assign side_p = side_in;
      assign vld_p  = valid_in;
    end else begin : g_next
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_p[l]  = rem_r[k-1][l];
        assign quot_p[l] = quot_r[k-1][l];
      end
      assign len_p  = len_r[k-1];
      assign side_p = side_r[k-1];
      assign vld_p  = vld_r[k-1];
    end

    assign sub_c = RW'(len_p) << (QW - 1 - k);

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rem_p[l] >= sub_c) begin
          rem_nxt[l]  = rem_p[l] - sub_c;
          quot_nxt[l] = {quot_p[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l]  = rem_p[l];
          quot_nxt[l] = {quot_p[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem_r[k][l]  <= rem_nxt[l];
          quot_r[k][l] <= quot_nxt[l];
        end
        len_r[k]  <= len_p;
        side_r[k] <= side_p;
      end
    end
  end

  assign valid_out = vld_r[QW-1];
  assign side_out  = side_r[QW-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quot_out[l] = quot_r[QW-1][l];
  end

endmodule

>>> rtl/sphere_wall_slide_vector_top.sv
// ----------------------------------------------------------------------------
// sphere_wall_slide_vector_top: wall sliding direction on a sphere
// Projects the move direction onto the sphere tangent plane and normalizes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one query per
//   transaction: sphere centre, current and next position in signed Q16.16.
//   The output channel (out_valid, out_stall, out_data) returns one result
//   per query, in order: the unit slide direction in signed
//   Q2.UNIT_FRAC_BITS and a degenerate flag that is set, with zero slide
//   fields, when the move, the normal or the projected move has zero length.
//   A fully pipelined datapath takes one query every cycle while in_stall is
//   low. From acceptance to out_valid a query passes 13 stages of scaling
//   and products, 32 square root stages, one divider stage per quotient bit
//   and a saturation stage.
//   A one-entry skid register behind the last stage lets the pipeline take
//   one more query while a result waits; after that in_stall rises and the
//   whole pipeline holds until out_stall drops. Nothing is lost or repeated.
//   Synchronous reset clears the valid bits and the skid full flag; the
//   data registers, the skid data included, are not reset.
// ----------------------------------------------------------------------------
module sphere_wall_slide_vector_top #(
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  swsv_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output swsv_pkg::out_t  out_data
);

  localparam int QW = UNIT_FRAC_BITS + 1;

  logic en;
  logic skid_full_r;
  swsv_pkg::out_t skid_r;

  assign en = !skid_full_r;

  // Stage A: move and normal vectors.
  logic signed [32:0] d_a_r [3];
  logic signed [32:0] n_a_r [3];
  logic               v_a_r;

  // Stage B: magnitudes and signs.
  logic [32:0] dm_b_r [3];
  logic [32:0] nm_b_r [3];
  logic [2:0]  dneg_b_r, nneg_b_r;
  logic        v_b_r;

  // Stage C: leading-one positions.
  logic [32:0] dm_c_r [3];
  logic [32:0] nm_c_r [3];
  logic [2:0]  dneg_c_r, nneg_c_r;
  logic [5:0]  dp_c_r, np_c_r;
  logic        dz_c_r, nz_c_r;
  logic        v_c_r;

  // Stage D: block-scaled vectors.
  logic signed [20:0] ds_d_r [3];
  logic signed [20:0] ns_d_r [3];
  logic               deg_d_r;
  logic               v_d_r;

  // Stage E: component products.
  logic signed [20:0] ds_e_r [3];
  logic signed [20:0] ns_e_r [3];
  logic signed [41:0] nsq_e_r [3];
  logic signed [41:0] dnp_e_r [3];
  logic               deg_e_r;
  logic               v_e_r;

  // Stage F: dot products.
  logic signed [20:0] ds_f_r [3];
  logic signed [20:0] ns_f_r [3];
  logic signed [43:0] nn_f_r, dn_f_r;
  logic               deg_f_r;
  logic               v_f_r;

  // Stage G: scaled products.
  logic signed [64:0] pa_g_r [3];
  logic signed [64:0] pb_g_r [3];
  logic               deg_g_r;
  logic               v_g_r;

  // Stage H: projected move.
  logic signed [64:0] s_h_r [3];
  logic               deg_h_r;
  logic               v_h_r;

  // Stage I: magnitudes of the projected move.
  logic [62:0] sm_i_r [3];
  logic [2:0]  sneg_i_r;
  logic        deg_i_r;
  logic        v_i_r;

  // Stage J: leading-one position.
  logic [62:0] sm_j_r [3];
  logic [2:0]  sneg_j_r;
  logic [5:0]  sp_j_r;
  logic        sz_j_r;
  logic        deg_j_r;
  logic        v_j_r;

  // Stage K: scaled magnitudes, the largest in [2^30, 2^31).
  logic [30:0] m_k_r [3];
  logic [2:0]  sneg_k_r;
  logic        deg_k_r;
  logic        v_k_r;

  // Stage L: squares.
  logic [30:0] m_l_r [3];
  logic [61:0] sq_l_r [3];
  logic [2:0]  sneg_l_r;
  logic        deg_l_r;
  logic        v_l_r;

  // Stage M: sum of squares.
  logic [63:0]           sum_m_r;
  swsv_pkg::sqrt_side_t  side_m_r;
  logic                  v_m_r;

  logic [32:0] dm_nxt [3];
  logic [32:0] nm_nxt [3];
  logic [32:0] dmx_nxt, nmx_nxt;
  logic [19:0] dsm_nxt [3];
  logic [19:0] nsm_nxt [3];
  logic [62:0] sm_nxt [3];
  logic [62:0] smx_nxt;
  logic [30:0] m_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm_nxt[i] = d_a_r[i][32] ? 33'(-d_a_r[i]) : 33'(d_a_r[i]);
      nm_nxt[i] = n_a_r[i][32] ? 33'(-n_a_r[i]) : 33'(n_a_r[i]);
      dsm_nxt[i] = 20'((52'(dm_c_r[i]) << 19) >> dp_c_r);
      nsm_nxt[i] = 20'((52'(nm_c_r[i]) << 19) >> np_c_r);
      sm_nxt[i] = s_h_r[i][64] ? 63'(-s_h_r[i]) : 63'(s_h_r[i]);
      m_nxt[i] = 31'((93'(sm_j_r[i]) << 30) >> sp_j_r);
    end
    dmx_nxt = dm_b_r[0];
    nmx_nxt = nm_b_r[0];
    smx_nxt = sm_i_r[0];
    for (int i = 1; i < 3; i++) begin
      if (dm_b_r[i] > dmx_nxt) dmx_nxt = dm_b_r[i];
      if (nm_b_r[i] > nmx_nxt) nmx_nxt = nm_b_r[i];
      if (sm_i_r[i] > smx_nxt) smx_nxt = sm_i_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0; v_b_r <= 1'b0; v_c_r <= 1'b0; v_d_r <= 1'b0;
      v_e_r <= 1'b0; v_f_r <= 1'b0; v_g_r <= 1'b0; v_h_r <= 1'b0;
      v_i_r <= 1'b0; v_j_r <= 1'b0; v_k_r <= 1'b0; v_l_r <= 1'b0;
      v_m_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_valid; v_b_r <= v_a_r; v_c_r <= v_b_r; v_d_r <= v_c_r;
      v_e_r <= v_d_r;    v_f_r <= v_e_r; v_g_r <= v_f_r; v_h_r <= v_g_r;
      v_i_r <= v_h_r;    v_j_r <= v_i_r; v_k_r <= v_j_r; v_l_r <= v_k_r;
      v_m_r <= v_l_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_a_r[0] <= 33'(in_data.next_x) - 33'(in_data.cur_x);
      d_a_r[1] <= 33'(in_data.next_y) - 33'(in_data.cur_y);
      d_a_r[2] <= 33'(in_data.next_z) - 33'(in_data.cur_z);
      n_a_r[0] <= 33'(in_data.cur_x) - 33'(in_data.centre_x);
      n_a_r[1] <= 33'(in_data.cur_y) - 33'(in_data.centre_y);
      n_a_r[2] <= 33'(in_data.cur_z) - 33'(in_data.centre_z);

      for (int i = 0; i < 3; i++) begin
        dm_b_r[i]   <= dm_nxt[i];
        nm_b_r[i]   <= nm_nxt[i];
        dneg_b_r[i] <= d_a_r[i][32];
        nneg_b_r[i] <= n_a_r[i][32];
      end

      dm_c_r   <= dm_b_r;
      nm_c_r   <= nm_b_r;
      dneg_c_r <= dneg_b_r;
      nneg_c_r <= nneg_b_r;
      dp_c_r   <= swsv_pkg::msb_pos(64'(dmx_nxt));
      np_c_r   <= swsv_pkg::msb_pos(64'(nmx_nxt));
      dz_c_r   <= (dmx_nxt == '0);
      nz_c_r   <= (nmx_nxt == '0);

      for (int i = 0; i < 3; i++) begin
        ds_d_r[i] <= dneg_c_r[i] ? -$signed({1'b0, dsm_nxt[i]}) : $signed({1'b0, dsm_nxt[i]});
        ns_d_r[i] <= nneg_c_r[i] ? -$signed({1'b0, nsm_nxt[i]}) : $signed({1'b0, nsm_nxt[i]});
      end
      deg_d_r <= dz_c_r | nz_c_r;

      for (int i = 0; i < 3; i++) begin
        nsq_e_r[i] <= 42'(ns_d_r[i]) * 42'(ns_d_r[i]);
        dnp_e_r[i] <= 42'(ds_d_r[i]) * 42'(ns_d_r[i]);
      end
      ds_e_r  <= ds_d_r;
      ns_e_r  <= ns_d_r;
      deg_e_r <= deg_d_r;

      nn_f_r  <= 44'(nsq_e_r[0]) + 44'(nsq_e_r[1]) + 44'(nsq_e_r[2]);
      dn_f_r  <= 44'(dnp_e_r[0]) + 44'(dnp_e_r[1]) + 44'(dnp_e_r[2]);
      ds_f_r  <= ds_e_r;
      ns_f_r  <= ns_e_r;
      deg_f_r <= deg_e_r;

      for (int i = 0; i < 3; i++) begin
        pa_g_r[i] <= 65'(ds_f_r[i]) * 65'(nn_f_r);
        pb_g_r[i] <= 65'(ns_f_r[i]) * 65'(dn_f_r);
      end
      deg_g_r <= deg_f_r;

      for (int i = 0; i < 3; i++) begin
        s_h_r[i] <= pa_g_r[i] - pb_g_r[i];
      end
      deg_h_r <= deg_g_r;

      for (int i = 0; i < 3; i++) begin
        sm_i_r[i]   <= sm_nxt[i];
        sneg_i_r[i] <= s_h_r[i][64];
      end
      deg_i_r <= deg_h_r;

      sm_j_r   <= sm_i_r;
      sneg_j_r <= sneg_i_r;
      sp_j_r   <= swsv_pkg::msb_pos(64'(smx_nxt));
      sz_j_r   <= (smx_nxt == '0);
      deg_j_r  <= deg_i_r;

      m_k_r    <= m_nxt;
      sneg_k_r <= sneg_j_r;
      deg_k_r  <= deg_j_r | sz_j_r;

      for (int i = 0; i < 3; i++) begin
        sq_l_r[i] <= 62'(m_k_r[i]) * 62'(m_k_r[i]);
      end
      m_l_r    <= m_k_r;
      sneg_l_r <= sneg_k_r;
      deg_l_r  <= deg_k_r;

      sum_m_r <= 64'(sq_l_r[0]) + 64'(sq_l_r[1]) + 64'(sq_l_r[2]);
      for (int i = 0; i < 3; i++) begin
        side_m_r.mag[i] <= m_l_r[i];
      end
      side_m_r.neg   <= sneg_l_r;
      side_m_r.degen <= deg_l_r;
    end
  end

  // Square root of the sum of squares.
  logic                 sq_valid;
  logic [31:0]          sq_len;
  swsv_pkg::sqrt_side_t sq_side;

  swsv_isqrt #(
    .SIDE_W($bits(swsv_pkg::sqrt_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (v_m_r),
    .x_in      (sum_m_r),
    .side_in   (side_m_r),
    .valid_out (sq_valid),
    .root_out  (sq_len),
    .side_out  (sq_side)
  );

  // Rounding division of each magnitude by the length.
  swsv_pkg::div_side_t  dv_side_in, dv_side;
  logic                 dv_valid;
  logic [2:0][QW-1:0]   dv_quot;

  assign dv_side_in.neg   = sq_side.neg;
  assign dv_side_in.degen = sq_side.degen | (sq_len == '0);

  swsv_div #(
    .FRAC_BITS(UNIT_FRAC_BITS),
    .SIDE_W   ($bits(swsv_pkg::div_side_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (sq_valid),
    .mag_in    (sq_side.mag),
    .len_in    (sq_len),
    .side_in   (dv_side_in),
    .valid_out (dv_valid),
    .quot_out  (dv_quot),
    .side_out  (dv_side)
  );

  // Saturation and sign stage.
  logic [15:0]    lane_nxt [3];
  logic [31:0]    qw, qc;
  swsv_pkg::out_t res_nxt;
  swsv_pkg::out_t res_z_r;
  logic           v_z_r;

  always_comb begin
    qw = '0;
    qc = '0;
    for (int i = 0; i < 3; i++) begin
      qw = 32'(dv_quot[i]);
      if (dv_side.neg[i]) begin
        qc = (qw > swsv_pkg::SAT_NEG) ? swsv_pkg::SAT_NEG : qw;
        lane_nxt[i] = ~qc[15:0] + 16'd1;
      end else begin
        qc = (qw > swsv_pkg::SAT_POS) ? swsv_pkg::SAT_POS : qw;
        lane_nxt[i] = qc[15:0];
      end
      if (dv_side.degen) lane_nxt[i] = '0;
    end
    res_nxt.slide_x    = $signed(lane_nxt[0]);
    res_nxt.slide_y    = $signed(lane_nxt[1]);
    res_nxt.slide_z    = $signed(lane_nxt[2]);
    res_nxt.degenerate = dv_side.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_z_r <= 1'b0;
    end else if (en) begin
      v_z_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_z_r <= res_nxt;
  end

  // Skid register: catches the last stage when the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      skid_full_r <= out_stall;
    end else begin
      skid_full_r <= v_z_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r && v_z_r && out_stall) skid_r <= res_z_r;
  end

  assign in_stall  = skid_full_r;
  assign out_valid = skid_full_r | v_z_r;
  assign out_data  = skid_full_r ? skid_r : res_z_r;

  // A degenerate result carries zero slide fields.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.slide_x == '0 && out_data.slide_y == '0 && out_data.slide_z == '0)
    else $error("degenerate result with nonzero slide");

  // After scaling, a live projected move has its largest magnitude at bit 30.
  a_scale_top: assert property (@(posedge clk) disable iff (!rst_n)
    v_k_r && !deg_k_r |-> (m_k_r[0][30] || m_k_r[1][30] || m_k_r[2][30]))
    else $error("projected move not normalized to the top bit");

  // The length of a scaled nonzero vector is at least 2^30.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    sq_valid && !sq_side.degen |-> sq_len[31:30] != 2'b00)
    else $error("square root result out of range");

  // The skid register drains in the cycle after the stall is released.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r && !out_stall |=> !skid_full_r)
    else $error("skid register failed to drain");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for sphere_wall_slide_vector_top
// Drives directed and random wall slide queries with random gaps and result
// stalls, predicts each slide direction and checks results in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC = 14;
  localparam int LATENCY = FRAC + 47;
  localparam int IDLE_LIMIT = 20000;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  swsv_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  swsv_pkg::out_t out_data;

  sphere_wall_slide_vector_top #(.UNIT_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  swsv_pkg::in_t  query_q[$];
  swsv_pkg::out_t slide_q[$];
  bit   failed = 0;
  bit   stim_done = 0;
  bit   in_fire = 0;
  int   idle_cycles = 0;
  int   send_wait = 0;
  int   recv_wait = 0;

  initial clk = 0;
  always #5 clk = ~clk;

  // Common power-of-two scaling so the largest magnitude is in [2^(top-1), 2^top).
  function automatic bit scale_vec(ref longint v[3], input int top);
    longint unsigned m[3];
    bit neg[3];
    longint unsigned mx;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << top)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << (top - 1))) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) v[i] = neg[i] ? -longint'(m[i]) : longint'(m[i]);
    return 1;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic swsv_pkg::out_t slide_direction(swsv_pkg::in_t q);
    longint d[3], n[3], s[3];
    longint cen[3], cur[3], nxt[3];
    longint nn, dn;
    longint unsigned sum, len, m, quo;
    logic signed [15:0] r[3];
    swsv_pkg::out_t o;
    cen = '{q.centre_x, q.centre_y, q.centre_z};
    cur = '{q.cur_x, q.cur_y, q.cur_z};
    nxt = '{q.next_x, q.next_y, q.next_z};
    o = '0;
    o.degenerate = 1;
    for (int i = 0; i < 3; i++) begin
      d[i] = nxt[i] - cur[i];
      n[i] = cur[i] - cen[i];
    end
    if (!scale_vec(d, 20) || !scale_vec(n, 20)) return o;
    nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    dn = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
    for (int i = 0; i < 3; i++) s[i] = d[i] * nn - n[i] * dn;
    if (!scale_vec(s, 31)) return o;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = s[i] < 0 ? -s[i] : s[i];
      sum += m * m;
    end
    len = int_sqrt(sum);
    if (len == 0) return o;
    for (int i = 0; i < 3; i++) begin
      m = s[i] < 0 ? -s[i] : s[i];
      quo = ((m << FRAC) + (len >> 1)) / len;
      if (s[i] < 0) begin
        if (quo > 32768) quo = 32768;
        r[i] = 16'(-longint'(quo));
      end else begin
        if (quo > 32767) quo = 32767;
        r[i] = 16'(quo);
      end
    end
    o.slide_x = r[0];
    o.slide_y = r[1];
    o.slide_z = r[2];
    o.degenerate = 0;
    return o;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000 + $urandom_range(0, 3);
      1: return 32'sh7fff_ffff - $urandom_range(0, 3);
      2: return $signed(32'($urandom_range(0, 2000))) - 1000;
      3: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic swsv_pkg::in_t rand_query();
    swsv_pkg::in_t q;
    int m;
    q.centre_x = rand_coord(); q.centre_y = rand_coord(); q.centre_z = rand_coord();
    q.cur_x = rand_coord(); q.cur_y = rand_coord(); q.cur_z = rand_coord();
    q.next_x = rand_coord(); q.next_y = rand_coord(); q.next_z = rand_coord();
    m = $urandom_range(0, 19);
    if (m == 0) {q.next_x, q.next_y, q.next_z} = {q.cur_x, q.cur_y, q.cur_z};
    if (m == 1) {q.centre_x, q.centre_y, q.centre_z} = {q.cur_x, q.cur_y, q.cur_z};
    if (m == 2) begin
      // Move straight out along the normal, so nothing is left to slide on.
      q.centre_x = $signed(32'($urandom_range(0, 200))) - 100;
      q.centre_y = $signed(32'($urandom_range(0, 200))) - 100;
      q.centre_z = $signed(32'($urandom_range(0, 200))) - 100;
      q.cur_x = q.centre_x + 3; q.cur_y = q.centre_y - 5; q.cur_z = q.centre_z + 7;
      q.next_x = q.cur_x + 6; q.next_y = q.cur_y - 10; q.next_z = q.cur_z + 14;
    end
    return q;
  endfunction

  function automatic swsv_pkg::in_t make_query(logic signed [31:0] cx, cy, cz, ux, uy, uz,
                                               vx, vy, vz);
    swsv_pkg::in_t q;
    q.centre_x = cx; q.centre_y = cy; q.centre_z = cz;
    q.cur_x = ux; q.cur_y = uy; q.cur_z = uz;
    q.next_x = vx; q.next_y = vy; q.next_z = vz;
    return q;
  endfunction

  initial begin
    logic signed [31:0] mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    query_q.push_back(make_query(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 0));
    query_q.push_back(make_query(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0));
    query_q.push_back(make_query(5, 5, 5, 5, 5, 5, 9, 1, 3));
    query_q.push_back(make_query(0, 0, 0, 1, 0, 0, 2, 0, 0));
    query_q.push_back(make_query(0, 0, 0, 1, 0, 0, -4, 0, 0));
    query_q.push_back(make_query(mn, mn, mn, mx, mx, mx, mn, mx, mn));
    query_q.push_back(make_query(mx, mx, mx, mn, mn, mn, mx, mn, mx));
    query_q.push_back(make_query(mn, mx, mn, mx, mn, mx, mx, mx, mn));
    query_q.push_back(make_query(0, 0, 0, mx, 0, 0, mx, 1, 0));
    query_q.push_back(make_query(mx, 0, 0, mn, 0, 0, mn, 0, 1));
    query_q.push_back(make_query(0, 0, 0, 1, 1, 0, 1, 1, 1));
    query_q.push_back(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    query_q.push_back(make_query(0, 0, 0, 0, 0, 1, 1, 0, 1));
    query_q.push_back(make_query(0, 0, 0, 0, 0, -1, -1, -1, -1));
    query_q.push_back(make_query(0, 0, 0, 3, 4, 0, 3, 4, mx));
    query_q.push_back(make_query(mn, mn, mn, mn, mn, mn + 1, mn + 1, mn, mn + 1));
    repeat (450) query_q.push_back(rand_query());
  end

  // Remembers whether the input transaction was taken at the last rising edge.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
  end

  // Driver: gaps drawn per item, payload held while stalled.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data <= '0;
    end else if (in_valid && in_fire) begin
      if (query_q.size() > 0 && send_wait == 0 && $urandom_range(0, 1) == 0) begin
        in_data <= query_q.pop_front();
      end else begin
        in_valid <= 0;
        send_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      end
    end else if (!in_valid) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (query_q.size() > 0) begin
        in_valid <= 1;
        in_data <= query_q.pop_front();
      end else begin
        stim_done = 1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
      if (out_valid) recv_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
    end
  end

  // Monitor: predict at input acceptance, check at output acceptance.
  always @(posedge clk) begin
    swsv_pkg::out_t want;
    bit acc;
    acc = 0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        slide_q.push_back(slide_direction(in_data));
        acc = 1;
      end
      if (out_valid && !out_stall) begin
        acc = 1;
        if (slide_q.size() == 0) begin
          $error("result with no query outstanding: %p", out_data);
          failed = 1;
        end else begin
          want = slide_q.pop_front();
          if (out_data.slide_x !== want.slide_x) begin
            $error("slide_x expected %0d got %0d", want.slide_x, out_data.slide_x);
            failed = 1;
          end
          if (out_data.slide_y !== want.slide_y) begin
            $error("slide_y expected %0d got %0d", want.slide_y, out_data.slide_y);
            failed = 1;
          end
          if (out_data.slide_z !== want.slide_z) begin
            $error("slide_z expected %0d got %0d", want.slide_z, out_data.slide_z);
            failed = 1;
          end
          if (out_data.degenerate !== want.degenerate) begin
            $error("degenerate expected %0d got %0d", want.degenerate,
                   out_data.degenerate);
            failed = 1;
          end
        end
      end
      idle_cycles <= acc ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    fork
      begin
        wait (stim_done && slide_q.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (slide_q.size() != 0) begin
          $error("%0d results still outstanding", slide_q.size());
          failed = 1;
        end
      end
      wait (idle_cycles >= IDLE_LIMIT);
    join_any
    if (idle_cycles >= IDLE_LIMIT) begin
      $error("timeout with no transaction accepted");
      failed = 1;
    end
    if (!failed) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
